// ----- rtl/dsl_byte_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer modules; they use clk and rst_n in scope.
`ifndef DSL_BYTE_TOKENIZER_ASSERT_SVH
`define DSL_BYTE_TOKENIZER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check
`define DSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check
`define DSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DSL_ASSERT_IMP(lbl, ante, cons, msg)
`define DSL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/dsl_tok_pkg.sv -----
// Types, token codes and keyword table for the byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package dsl_tok_pkg;

  localparam int POS_WIDTH           = 16;
  localparam int KEYWORD_MAX_LEN_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 4;
  localparam int NUM_KEYWORDS        = 12;
  localparam int KW_TEXT_BYTES       = 8;

  localparam logic [15:0] LEN_MAX   = 16'hFFFF;
  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  // Token kinds
  localparam logic [5:0] K_END       = 6'd0;
  localparam logic [5:0] K_ERROR     = 6'd1;
  localparam logic [5:0] K_IDENT     = 6'd2;
  localparam logic [5:0] K_INT       = 6'd3;
  localparam logic [5:0] K_KW0       = 6'd4;
  localparam logic [5:0] OP_LPAREN   = 6'd16;
  localparam logic [5:0] OP_RPAREN   = 6'd17;
  localparam logic [5:0] OP_LBRACE   = 6'd18;
  localparam logic [5:0] OP_RBRACE   = 6'd19;
  localparam logic [5:0] OP_SEMI     = 6'd20;
  localparam logic [5:0] OP_COMMA    = 6'd21;
  localparam logic [5:0] OP_PLUS     = 6'd22;
  localparam logic [5:0] OP_MINUS    = 6'd23;
  localparam logic [5:0] OP_STAR     = 6'd24;
  localparam logic [5:0] OP_SLASH    = 6'd25;
  localparam logic [5:0] OP_NE       = 6'd26;
  localparam logic [5:0] OP_NOT      = 6'd27;
  localparam logic [5:0] OP_EQEQ     = 6'd28;
  localparam logic [5:0] OP_ASSIGN   = 6'd29;
  localparam logic [5:0] OP_LE       = 6'd30;
  localparam logic [5:0] OP_LT       = 6'd31;
  localparam logic [5:0] OP_GE       = 6'd32;
  localparam logic [5:0] OP_GT       = 6'd33;

  // Keyword text, right aligned: first character in the highest used byte
  localparam logic [8*KW_TEXT_BYTES-1:0] KW_STR [NUM_KEYWORDS] = '{
    64'("world"), 64'("robot"), 64'("target"), 64'("obstacle"),
    64'("behavior"), 64'("every"), 64'("tick"), 64'("if"),
    64'("else"), 64'("at"), 64'("true"), 64'("false")
  };
  localparam int KW_LEN [NUM_KEYWORDS] = '{5, 5, 6, 8, 8, 5, 4, 2, 4, 2, 4, 5};

  // What the lexer is holding open between bytes
  typedef enum logic [3:0] {
    P_NONE, P_NAME, P_NUM, P_COMMENT, P_SLASH, P_BANG, P_EQ, P_LT, P_GT
  } pend_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [5:0]           token_kind;
    logic [POS_WIDTH-1:0] start_line;
    logic [POS_WIDTH-1:0] start_column;
    logic [15:0]          lexeme_length;
    logic [30:0]          num_value;
    logic                 int_overflow;
    logic [7:0]           bad_byte;
    logic                 source_done;
    logic                 last_of_run;
  } out_tok_t;

  // One queue entry: the tokens caused by one transfer, in order
  typedef struct packed {
    logic     v0;
    out_tok_t t0;
    logic     v1;
    out_tok_t t1;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- rtl/dsl_tok_front.sv -----
// Front end: accepts bytes, tracks position and builds the tokens each byte closes.
`timescale 1ns / 1ps
`default_nettype none
`include "dsl_byte_tokenizer_assert.svh"
module dsl_tok_front #(
  parameter int KEYWORD_MAX_LEN = dsl_tok_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dsl_tok_pkg::in_item_t in_data,
  input  wire logic                  q_full,
  output logic                       push,
  output dsl_tok_pkg::q_entry_t      entry
);

  localparam int IDXW = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
  localparam logic [dsl_tok_pkg::POS_WIDTH-1:0] POS_ONE = 1;
  localparam logic [dsl_tok_pkg::POS_WIDTH-1:0] POS_MAX = '1;

  logic [dsl_tok_pkg::POS_WIDTH-1:0] cur_line_r, cur_line_nxt;
  logic [dsl_tok_pkg::POS_WIDTH-1:0] cur_col_r, cur_col_nxt;
  logic [dsl_tok_pkg::POS_WIDTH-1:0] tok_line_r, tok_line_nxt;
  logic [dsl_tok_pkg::POS_WIDTH-1:0] tok_col_r, tok_col_nxt;
  dsl_tok_pkg::pend_t                pend_r, pend_nxt;
  logic [7:0]                        kwbuf_r [KEYWORD_MAX_LEN];
  logic [7:0]                        kwbuf_nxt [KEYWORD_MAX_LEN];
  logic [15:0]                       tok_len_r, tok_len_nxt;
  logic [30:0]                       accum_r, accum_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              halted_r, halted_nxt;

  logic                              fire;
  logic [7:0]                        b;
  logic                              is_alpha, is_digit, is_blank;
  logic [dsl_tok_pkg::POS_WIDTH-1:0] adv_line, adv_col;
  logic [34:0]                       acc_sum;
  logic                              flush_v;
  logic                              v0, v1;
  dsl_tok_pkg::out_tok_t             tok0, tok1;

  // Match the held name against the keyword table
  function automatic logic [5:0] name_kind(input logic [7:0] buf_in [KEYWORD_MAX_LEN],
                                           input logic [15:0] len);
    logic [5:0] kind;
    logic       hit;
    kind = dsl_tok_pkg::K_IDENT;
    for (int i = 0; i < dsl_tok_pkg::NUM_KEYWORDS; i++) begin
      if (dsl_tok_pkg::KW_LEN[i] <= KEYWORD_MAX_LEN &&
          len == 16'(dsl_tok_pkg::KW_LEN[i])) begin
        hit = 1'b1;
        for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
          if (j < dsl_tok_pkg::KW_LEN[i] &&
              buf_in[j] != dsl_tok_pkg::KW_STR[i][8*(dsl_tok_pkg::KW_LEN[i]-1-j) +: 8]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          kind = dsl_tok_pkg::K_KW0 + 6'(i);
        end
      end
    end
    return kind;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign b        = in_data.source_byte;

  // Classify the byte
  assign is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  assign is_digit = (b >= "0" && b <= "9");
  assign is_blank = (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);

  // Advance position, saturating
  always_comb begin
    adv_line = cur_line_r;
    adv_col  = cur_col_r;
    if (b == 8'h0A) begin
      if (cur_line_r != POS_MAX) adv_line = cur_line_r + POS_ONE;
      adv_col = POS_ONE;
    end else if (cur_col_r != POS_MAX) begin
      adv_col = cur_col_r + POS_ONE;
    end
  end

  // Times-ten accumulate
  assign acc_sum = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + {31'b0, b[3:0]};

  // Build the token that closing the pending item would emit
  always_comb begin
    tok0              = '0;
    tok0.start_line   = tok_line_r;
    tok0.start_column = tok_col_r;
    tok0.lexeme_length = 16'd1;
    flush_v           = 1'b1;
    unique case (pend_r)
      dsl_tok_pkg::P_NAME: begin
        tok0.token_kind    = name_kind(kwbuf_r, tok_len_r);
        tok0.lexeme_length = tok_len_r;
      end
      dsl_tok_pkg::P_NUM: begin
        tok0.token_kind    = dsl_tok_pkg::K_INT;
        tok0.lexeme_length = tok_len_r;
        tok0.num_value     = accum_r;
        tok0.int_overflow  = ovf_r;
      end
      dsl_tok_pkg::P_SLASH: tok0.token_kind = dsl_tok_pkg::OP_SLASH;
      dsl_tok_pkg::P_BANG:  tok0.token_kind = dsl_tok_pkg::OP_NOT;
      dsl_tok_pkg::P_EQ:    tok0.token_kind = dsl_tok_pkg::OP_ASSIGN;
      dsl_tok_pkg::P_LT:    tok0.token_kind = dsl_tok_pkg::OP_LT;
      dsl_tok_pkg::P_GT:    tok0.token_kind = dsl_tok_pkg::OP_GT;
      default:              flush_v = 1'b0;
    endcase
  end

  // Next state and the tokens of this transfer
  always_comb begin
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    pend_nxt     = pend_r;
    kwbuf_nxt    = kwbuf_r;
    tok_len_nxt  = tok_len_r;
    accum_nxt    = accum_r;
    ovf_nxt      = ovf_r;
    halted_nxt   = halted_r;
    v0           = 1'b0;
    v1           = 1'b0;
    tok1         = '0;
    if (fire) begin
      if (in_data.end_marker) begin
        // close the source and return to the reset state
        v0                = !halted_r && flush_v;
        v1                = !halted_r;
        tok1.token_kind   = dsl_tok_pkg::K_END;
        tok1.start_line   = cur_line_r;
        tok1.start_column = cur_col_r;
        tok1.source_done  = 1'b1;
        cur_line_nxt      = POS_ONE;
        cur_col_nxt       = POS_ONE;
        tok_line_nxt      = POS_ONE;
        tok_col_nxt       = POS_ONE;
        pend_nxt          = dsl_tok_pkg::P_NONE;
        tok_len_nxt       = '0;
        accum_nxt         = '0;
        ovf_nxt           = 1'b0;
        halted_nxt        = 1'b0;
        for (int k = 0; k < KEYWORD_MAX_LEN; k++) kwbuf_nxt[k] = '0;
      end else if (!halted_r) begin
        cur_line_nxt = adv_line;
        cur_col_nxt  = adv_col;
        if (pend_r == dsl_tok_pkg::P_NAME && (is_alpha || is_digit)) begin
          // extend a name
          if (tok_len_r < 16'(KEYWORD_MAX_LEN)) kwbuf_nxt[tok_len_r[IDXW-1:0]] = b;
          if (tok_len_r != dsl_tok_pkg::LEN_MAX) tok_len_nxt = tok_len_r + 16'd1;
        end else if (pend_r == dsl_tok_pkg::P_NUM && is_digit) begin
          // extend a number, saturating
          if (acc_sum > {4'b0, dsl_tok_pkg::INT_MAX31}) begin
            accum_nxt = dsl_tok_pkg::INT_MAX31;
            ovf_nxt   = 1'b1;
          end else begin
            accum_nxt = acc_sum[30:0];
          end
          if (tok_len_r != dsl_tok_pkg::LEN_MAX) tok_len_nxt = tok_len_r + 16'd1;
        end else if (pend_r == dsl_tok_pkg::P_COMMENT && b != 8'h0A) begin
          // stay in the comment
        end else if (pend_r == dsl_tok_pkg::P_SLASH && b == "/") begin
          pend_nxt = dsl_tok_pkg::P_COMMENT;
        end else if ((pend_r == dsl_tok_pkg::P_BANG || pend_r == dsl_tok_pkg::P_EQ ||
                      pend_r == dsl_tok_pkg::P_LT || pend_r == dsl_tok_pkg::P_GT) &&
                     b == "=") begin
          // two-character operator
          v1                 = 1'b1;
          tok1.start_line    = tok_line_r;
          tok1.start_column  = tok_col_r;
          tok1.lexeme_length = 16'd2;
          unique case (pend_r)
            dsl_tok_pkg::P_BANG: tok1.token_kind = dsl_tok_pkg::OP_NE;
            dsl_tok_pkg::P_EQ:   tok1.token_kind = dsl_tok_pkg::OP_EQEQ;
            dsl_tok_pkg::P_LT:   tok1.token_kind = dsl_tok_pkg::OP_LE;
            default:             tok1.token_kind = dsl_tok_pkg::OP_GE;
          endcase
          pend_nxt = dsl_tok_pkg::P_NONE;
        end else begin
          // close what is pending, then start on this byte
          v0                 = flush_v;
          pend_nxt           = dsl_tok_pkg::P_NONE;
          tok_line_nxt       = cur_line_r;
          tok_col_nxt        = cur_col_r;
          tok1.start_line    = cur_line_r;
          tok1.start_column  = cur_col_r;
          tok1.lexeme_length = 16'd1;
          if (is_blank) begin
            // skip
          end else if (is_alpha) begin
            for (int k = 0; k < KEYWORD_MAX_LEN; k++) kwbuf_nxt[k] = '0;
            kwbuf_nxt[0] = b;
            tok_len_nxt  = 16'd1;
            pend_nxt     = dsl_tok_pkg::P_NAME;
          end else if (is_digit) begin
            tok_len_nxt = 16'd1;
            accum_nxt   = {27'b0, b[3:0]};
            ovf_nxt     = 1'b0;
            pend_nxt    = dsl_tok_pkg::P_NUM;
          end else begin
            v1 = 1'b1;
            case (b)
              "/": begin v1 = 1'b0; pend_nxt = dsl_tok_pkg::P_SLASH; end
              "!": begin v1 = 1'b0; pend_nxt = dsl_tok_pkg::P_BANG; end
              "=": begin v1 = 1'b0; pend_nxt = dsl_tok_pkg::P_EQ; end
              "<": begin v1 = 1'b0; pend_nxt = dsl_tok_pkg::P_LT; end
              ">": begin v1 = 1'b0; pend_nxt = dsl_tok_pkg::P_GT; end
              "(": tok1.token_kind = dsl_tok_pkg::OP_LPAREN;
              ")": tok1.token_kind = dsl_tok_pkg::OP_RPAREN;
              "{": tok1.token_kind = dsl_tok_pkg::OP_LBRACE;
              "}": tok1.token_kind = dsl_tok_pkg::OP_RBRACE;
              ";": tok1.token_kind = dsl_tok_pkg::OP_SEMI;
              ",": tok1.token_kind = dsl_tok_pkg::OP_COMMA;
              "+": tok1.token_kind = dsl_tok_pkg::OP_PLUS;
              "-": tok1.token_kind = dsl_tok_pkg::OP_MINUS;
              "*": tok1.token_kind = dsl_tok_pkg::OP_STAR;
              default: begin
                // unexpected byte: report and halt until the end marker
                tok1.token_kind  = dsl_tok_pkg::K_ERROR;
                tok1.bad_byte    = b;
                tok1.source_done = 1'b1;
                halted_nxt       = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  assign push  = fire && (v0 || v1);
  assign entry = '{v0: v0, t0: tok0, v1: v1, t1: tok1};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_line_r <= POS_ONE;
      cur_col_r  <= POS_ONE;
      pend_r     <= dsl_tok_pkg::P_NONE;
      halted_r   <= 1'b0;
    end else begin
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      pend_r     <= pend_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    tok_line_r <= tok_line_nxt;
    tok_col_r  <= tok_col_nxt;
    kwbuf_r    <= kwbuf_nxt;
    tok_len_r  <= tok_len_nxt;
    accum_r    <= accum_nxt;
    ovf_r      <= ovf_nxt;
  end

  `DSL_ASSERT_IMP(a_halt_silent, halted_r && fire && !in_data.end_marker, !push, "halted front pushed")
  `DSL_ASSERT_IMP(a_flush_not_done, push && entry.v0, !entry.t0.source_done, "flushed token closes source")

endmodule
`default_nettype wire

// ----- rtl/dsl_tok_fifo.sv -----
// Short token queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "dsl_byte_tokenizer_assert.svh"
module dsl_tok_fifo #(
  parameter int DEPTH = dsl_tok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire dsl_tok_pkg::q_entry_t wr_data,
  input  wire logic                  pop,
  output dsl_tok_pkg::q_entry_t      head,
  output logic                       q_valid,
  output logic                       full
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  dsl_tok_pkg::q_entry_t mem_r [DEPTH];
  logic [PTRW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;

  assign head    = mem_r[rd_ptr_r];
  assign q_valid = (count_r != '0);
  assign full    = (count_r == CNTW'(DEPTH));

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `DSL_ASSERT_IMP(a_no_overrun, push, !full, "push into full queue")
  `DSL_ASSERT_IMP(a_no_underrun, pop, q_valid, "pop from empty queue")
  `DSL_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule
`default_nettype wire

// ----- rtl/dsl_tok_back.sv -----
// Back end: splits queue entries into single tokens and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "dsl_byte_tokenizer_assert.svh"
module dsl_tok_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dsl_tok_pkg::q_entry_t head,
  input  wire logic                  q_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dsl_tok_pkg::out_tok_t      out_data
);

  logic                  out_valid_r, out_valid_nxt;
  dsl_tok_pkg::out_tok_t out_data_r, out_data_nxt;
  logic                  sel_r, sel_nxt;
  logic                  load;

  assign load = !out_valid_r || out_ready;

  // Pick the next token of the head entry and tag the last one
  always_comb begin
    pop           = 1'b0;
    sel_nxt       = sel_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load && q_valid) begin
      out_valid_nxt = 1'b1;
      if (!sel_r && head.v0) begin
        out_data_nxt             = head.t0;
        out_data_nxt.last_of_run = !head.v1;
        if (head.v1) begin
          sel_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_data_nxt             = head.t1;
        out_data_nxt.last_of_run = 1'b1;
        pop                      = 1'b1;
        sel_nxt                  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DSL_ASSERT_IMP(a_second_slot_held, sel_r, q_valid && head.v1, "second token lost from queue head")

endmodule
`default_nettype wire

// ----- rtl/dsl_byte_tokenizer.sv -----
// Top level of the streaming byte tokenizer: front end, token queue, back end.
// Throughput: one byte per cycle in while the queue has room; one token per cycle out while out_ready is high.
// A byte's first closed token passes the queue write, then the output register load, before out_valid;
// the second token of a pair is loaded from the same queue entry after the first is taken.
// A byte closing two tokens takes two output register loads; a full queue drops in_ready.
// Reset: synchronous, active low; position 1/1, nothing pending, queue empty, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module dsl_byte_tokenizer #(
  parameter int KEYWORD_MAX_LEN = dsl_tok_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int QUEUE_DEPTH     = dsl_tok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dsl_tok_pkg::in_item_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dsl_tok_pkg::out_tok_t      out_data
);

  logic                  push, pop, q_valid, q_full;
  dsl_tok_pkg::q_entry_t wr_entry, head;

  dsl_tok_front #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  dsl_tok_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .head    (head),
    .q_valid (q_valid),
    .full    (q_full)
  );

  dsl_tok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the byte tokenizer: directed and random DSL sources checked against a token predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_BYTES = 1870;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int NAME_BUF     = dsl_tok_pkg::KEYWORD_MAX_LEN_DEF;
  localparam int REPORT_CAP   = 40;

  localparam logic [dsl_tok_pkg::POS_WIDTH-1:0] POS_SAT = '1;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  dsl_tok_pkg::in_item_t in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  dsl_tok_pkg::out_tok_t out_data;

  dsl_byte_tokenizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  string kw_words [12] = '{"world", "robot", "target", "obstacle", "behavior", "every",
                           "tick", "if", "else", "at", "true", "false"};
  string op_words [18] = '{"(", ")", "{", "}", ";", ",", "+", "-", "*", "/",
                           "!=", "!", "==", "=", "<=", "<", ">=", ">"};

  dsl_tok_pkg::in_item_t source_items [$];
  dsl_tok_pkg::out_tok_t expected_tokens [$];
  dsl_tok_pkg::out_tok_t run_toks [$];

  // Lexer state mirrored by the predictor
  logic [dsl_tok_pkg::POS_WIDTH-1:0] lx_line, lx_col, lx_tok_line, lx_tok_col;
  logic [15:0]                       lx_len;
  logic [30:0]                       lx_value;
  logic                              lx_ovf, lx_halted;
  dsl_tok_pkg::pend_t                lx_pend;
  logic [7:0]                        lx_name [NAME_BUF];

  int mismatch_count = 0;
  int tokens_seen    = 0;
  int cycle_count    = 0;

  // ---------------------------------------------------------------- predictor

  function automatic dsl_tok_pkg::out_tok_t make_tok(
      logic [5:0] kind, logic [dsl_tok_pkg::POS_WIDTH-1:0] line,
      logic [dsl_tok_pkg::POS_WIDTH-1:0] col, logic [15:0] len,
      logic [30:0] val, logic ovf, logic [7:0] bad, logic done);
    dsl_tok_pkg::out_tok_t t;
    t.token_kind    = kind;
    t.start_line    = line;
    t.start_column  = col;
    t.lexeme_length = len;
    t.num_value     = val;
    t.int_overflow  = ovf;
    t.bad_byte      = bad;
    t.source_done   = done;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  // Append one token to those of the current item
  function automatic void queue_tok(dsl_tok_pkg::out_tok_t t);
    run_toks.insert(run_toks.size(), t);
  endfunction

  function automatic void lex_restart();
    lx_line     = 1;
    lx_col      = 1;
    lx_tok_line = 1;
    lx_tok_col  = 1;
    lx_pend     = dsl_tok_pkg::P_NONE;
    foreach (lx_name[i]) lx_name[i] = 8'h00;
    lx_len      = 0;
    lx_value    = 0;
    lx_ovf      = 1'b0;
    lx_halted   = 1'b0;
  endfunction

  // Advance line/column past one byte, saturating both
  function automatic void step_position(logic [7:0] b);
    if (b == CH_LF) begin
      if (lx_line != POS_SAT) lx_line++;
      lx_col = 1;
    end else if (lx_col != POS_SAT) begin
      lx_col++;
    end
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [5:0] name_kind();
    logic hit;
    if (lx_len > NAME_BUF) return dsl_tok_pkg::K_IDENT;
    for (int k = 0; k < 12; k++) begin
      if (kw_words[k].len() == lx_len) begin
        hit = 1'b1;
        for (int j = 0; j < kw_words[k].len(); j++)
          if (lx_name[j] != kw_words[k][j]) hit = 1'b0;
        if (hit) return dsl_tok_pkg::K_KW0 + 6'(k);
      end
    end
    return dsl_tok_pkg::K_IDENT;
  endfunction

  function automatic logic [5:0] cmp_code(dsl_tok_pkg::pend_t p, logic doubled);
    case (p)
      dsl_tok_pkg::P_BANG: return doubled ? dsl_tok_pkg::OP_NE   : dsl_tok_pkg::OP_NOT;
      dsl_tok_pkg::P_EQ:   return doubled ? dsl_tok_pkg::OP_EQEQ : dsl_tok_pkg::OP_ASSIGN;
      dsl_tok_pkg::P_LT:   return doubled ? dsl_tok_pkg::OP_LE   : dsl_tok_pkg::OP_LT;
      default:             return doubled ? dsl_tok_pkg::OP_GE   : dsl_tok_pkg::OP_GT;
    endcase
  endfunction

  // Emit whatever token is held open; a comment emits nothing
  function automatic void flush_pending();
    dsl_tok_pkg::pend_t p;
    p = lx_pend;
    lx_pend = dsl_tok_pkg::P_NONE;
    case (p) inside
      dsl_tok_pkg::P_NAME:
        queue_tok(make_tok(name_kind(), lx_tok_line, lx_tok_col, lx_len,
                           31'd0, 1'b0, 8'd0, 1'b0));
      dsl_tok_pkg::P_NUM:
        queue_tok(make_tok(dsl_tok_pkg::K_INT, lx_tok_line, lx_tok_col, lx_len,
                           lx_value, lx_ovf, 8'd0, 1'b0));
      dsl_tok_pkg::P_SLASH:
        queue_tok(make_tok(dsl_tok_pkg::OP_SLASH, lx_tok_line, lx_tok_col, 16'd1,
                           31'd0, 1'b0, 8'd0, 1'b0));
      dsl_tok_pkg::P_BANG, dsl_tok_pkg::P_EQ, dsl_tok_pkg::P_LT, dsl_tok_pkg::P_GT:
        queue_tok(make_tok(cmp_code(p, 1'b0), lx_tok_line, lx_tok_col, 16'd1,
                           31'd0, 1'b0, 8'd0, 1'b0));
      default: ;
    endcase
  endfunction

  // Byte that does not extend the open token: start a new one
  function automatic void start_token(logic [7:0] b);
    logic [5:0] code;
    logic       one_char;
    lx_tok_line = lx_line;
    lx_tok_col  = lx_col;
    one_char    = 1'b0;
    code        = dsl_tok_pkg::K_ERROR;
    if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF) begin
      // blank: position only
    end else if (is_letter(b)) begin
      foreach (lx_name[i]) lx_name[i] = 8'h00;
      lx_name[0] = b;
      lx_len     = 1;
      lx_pend    = dsl_tok_pkg::P_NAME;
    end else if (is_digit(b)) begin
      lx_len   = 1;
      lx_value = 31'(b - "0");
      lx_ovf   = 1'b0;
      lx_pend  = dsl_tok_pkg::P_NUM;
    end else begin
      case (b)
        "/": lx_pend = dsl_tok_pkg::P_SLASH;
        "!": lx_pend = dsl_tok_pkg::P_BANG;
        "=": lx_pend = dsl_tok_pkg::P_EQ;
        "<": lx_pend = dsl_tok_pkg::P_LT;
        ">": lx_pend = dsl_tok_pkg::P_GT;
        "(": begin code = dsl_tok_pkg::OP_LPAREN; one_char = 1'b1; end
        ")": begin code = dsl_tok_pkg::OP_RPAREN; one_char = 1'b1; end
        "{": begin code = dsl_tok_pkg::OP_LBRACE; one_char = 1'b1; end
        "}": begin code = dsl_tok_pkg::OP_RBRACE; one_char = 1'b1; end
        ";": begin code = dsl_tok_pkg::OP_SEMI;   one_char = 1'b1; end
        ",": begin code = dsl_tok_pkg::OP_COMMA;  one_char = 1'b1; end
        "+": begin code = dsl_tok_pkg::OP_PLUS;   one_char = 1'b1; end
        "-": begin code = dsl_tok_pkg::OP_MINUS;  one_char = 1'b1; end
        "*": begin code = dsl_tok_pkg::OP_STAR;   one_char = 1'b1; end
        default: begin
          // unexpected byte: error token, then halt until the end marker
          queue_tok(make_tok(dsl_tok_pkg::K_ERROR, lx_tok_line, lx_tok_col, 16'd1,
                             31'd0, 1'b0, b, 1'b1));
          lx_halted = 1'b1;
        end
      endcase
      if (one_char)
        queue_tok(make_tok(code, lx_tok_line, lx_tok_col, 16'd1,
                           31'd0, 1'b0, 8'd0, 1'b0));
    end
    step_position(b);
  endfunction

  // Work out the tokens caused by one transferred item and queue them
  function automatic void tokenize_item(dsl_tok_pkg::in_item_t item);
    logic [7:0]  b;
    logic [34:0] grown;
    b = item.source_byte;
    run_toks.delete();
    if (item.end_marker) begin
      if (!lx_halted) begin
        flush_pending();
        queue_tok(make_tok(dsl_tok_pkg::K_END, lx_line, lx_col, 16'd0, 31'd0, 1'b0,
                           8'd0, 1'b1));
      end
      lex_restart();
    end else if (!lx_halted) begin
      if (lx_pend == dsl_tok_pkg::P_NAME && (is_letter(b) || is_digit(b))) begin
        if (lx_len < NAME_BUF) lx_name[lx_len] = b;
        if (lx_len != dsl_tok_pkg::LEN_MAX) lx_len++;
        step_position(b);
      end else if (lx_pend == dsl_tok_pkg::P_NUM && is_digit(b)) begin
        grown = lx_value * 35'd10 + 35'(b - "0");
        if (grown > 35'(dsl_tok_pkg::INT_MAX31)) begin
          lx_value = dsl_tok_pkg::INT_MAX31;
          lx_ovf   = 1'b1;
        end else begin
          lx_value = grown[30:0];
        end
        if (lx_len != dsl_tok_pkg::LEN_MAX) lx_len++;
        step_position(b);
      end else if (lx_pend == dsl_tok_pkg::P_COMMENT && b != CH_LF) begin
        step_position(b);
      end else if (lx_pend == dsl_tok_pkg::P_SLASH && b == "/") begin
        lx_pend = dsl_tok_pkg::P_COMMENT;
        step_position(b);
      end else if ((lx_pend == dsl_tok_pkg::P_BANG || lx_pend == dsl_tok_pkg::P_EQ ||
                    lx_pend == dsl_tok_pkg::P_LT || lx_pend == dsl_tok_pkg::P_GT) &&
                   b == "=") begin
        queue_tok(make_tok(cmp_code(lx_pend, 1'b1), lx_tok_line, lx_tok_col,
                           16'd2, 31'd0, 1'b0, 8'd0, 1'b0));
        lx_pend = dsl_tok_pkg::P_NONE;
        step_position(b);
      end else begin
        flush_pending();
        start_token(b);
      end
    end
    if (run_toks.size() != 0) begin
      run_toks[run_toks.size() - 1].last_of_run = 1'b1;
      foreach (run_toks[i]) expected_tokens.insert(expected_tokens.size(), run_toks[i]);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [7:0] b);
    dsl_tok_pkg::in_item_t item;
    item.source_byte = b;
    item.end_marker  = 1'b0;
    source_items.insert(source_items.size(), item);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_end(logic [7:0] b);
    dsl_tok_pkg::in_item_t item;
    item.source_byte = b;
    item.end_marker  = 1'b1;
    source_items.insert(source_items.size(), item);
  endtask

  function automatic logic [7:0] name_start_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return name_start_char();
  endfunction

  function automatic string random_lexeme();
    string s;
    int    n;
    s = "";
    case ($urandom_range(0, 15))
      0, 1, 2, 3: s = kw_words[$urandom_range(0, 11)];
      4: s = $sformatf("%s%c", kw_words[$urandom_range(0, 11)], name_char());
      5: begin
        s = kw_words[$urandom_range(0, 11)];
        s = s.substr(0, s.len() - 2);
      end
      6, 7: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        s = $sformatf("%c", name_start_char());
        repeat (n - 1) s = $sformatf("%s%c", s, name_char());
      end
      8, 9: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
        repeat (n) s = $sformatf("%s%c", s, 8'("0" + $urandom_range(0, 9)));
      end
      15: begin
        s = "//";
        repeat ($urandom_range(0, 10)) s = $sformatf("%s%c", s, 8'($urandom_range(32, 255)));
        if ($urandom_range(0, 3) != 0) s = {s, "\n"};
      end
      default: s = op_words[$urandom_range(0, 17)];
    endcase
    return s;
  endfunction

  // One source: well-formed tokens with random blanks, sometimes broken by a stray byte
  task automatic queue_random_source(output int added);
    string word;
    int    n_tok, noise_at;
    n_tok    = $urandom_range(1, 24);
    noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_tok - 1) : -1;
    added    = 0;
    for (int t = 0; t < n_tok; t++) begin
      if (t == noise_at) begin
        push_byte(8'($urandom_range(0, 255)));
        added++;
        // mostly ignored once the block has halted
        repeat ($urandom_range(0, 3)) begin
          push_byte(8'($urandom_range(0, 255)));
          added++;
        end
        break;
      end
      word = random_lexeme();
      push_text(word);
      added += word.len();
      case ($urandom_range(0, 7))
        2, 3:    begin push_text(" ");    added += 1; end
        4:       begin push_text("\n");   added += 1; end
        5:       begin push_text("\t");   added += 1; end
        6:       begin push_text("\r\n"); added += 2; end
        7:       begin push_text("   ");  added += 3; end
        default: ;
      endcase
    end
    push_end(8'($urandom_range(0, 255)));
    added++;
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left = 0;
  int idle_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) tokenize_item(in_data);
      // offer the next item only once the current one is transferred
      if (!in_valid || in_ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (source_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= source_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  rx_mode_t              rx_mode      = RX_OPEN;
  int                    stretch_left = 0;
  int                    hold_left    = 0;
  logic                  hold_done    = 1'b0;
  dsl_tok_pkg::out_tok_t want;

  task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: token transfer, expected none, actual kind %0d line %0d col %0d",
                     $time, out_data.token_kind, out_data.start_line, out_data.start_column);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.token_kind, out_data.token_kind);
          check_field("start_line", want.start_line, out_data.start_line);
          check_field("start_column", want.start_column, out_data.start_column);
          check_field("lexeme_length", want.lexeme_length, out_data.lexeme_length);
          check_field("num_value", want.num_value, out_data.num_value);
          check_field("int_overflow", want.int_overflow, out_data.int_overflow);
          check_field("bad_byte", want.bad_byte, out_data.bad_byte);
          check_field("source_done", want.source_done, out_data.source_done);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && tokens_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          rx_mode      = rx_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(4, 60);
        end
        stretch_left--;
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
          default:   out_ready <= (stretch_left % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dsl_byte_tokenizer regression: fail");
    $finish;
  end

  initial begin
    int added, random_bytes;
    lex_restart();

    // Digits then letters, two-char compare, comment running into the end marker
    push_text("12ab<=x//c");
    push_end(8'hFF);
    // Overflowing integer flushed by a bad byte; the rest of the source is dropped
    push_text("99999999999");
    push_byte(8'hFF);
    push_byte("a");
    push_end(8'h00);
    // Pending-free operator then a NUL byte
    push_text("(");
    push_byte(8'h00);
    push_end(8'h5A);

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      queue_random_source(added);
      random_bytes += added;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (source_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("dsl_byte_tokenizer regression: pass");
    end else begin
      $display("dsl_byte_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
